>>> rtl/fps_pkg.sv
// Shared types, constants and the exp table builder for the axis friction plant.
// Used by every module of the block but fps_mul; depends on nothing.
package fps_pkg;

    localparam int AXES_DEF       = 7;
    localparam int PEAKS_DEF      = 8;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int EXP_DEPTH_DEF  = 256;

    localparam int MUL_W          = 34;
    localparam int PROD_W         = 2 * MUL_W;
    localparam int DT_SHIFT       = 24;
    localparam int EXP_RANGE_LOG2 = 4;
    localparam longint unsigned RECIP_SPREAD_Q30 = 64'd1787897427;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // item function codes
    localparam logic [1:0] FUNC_STEP  = 2'd0;
    localparam logic [1:0] FUNC_COEF  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    // coefficient kinds
    localparam logic [2:0] KIND_INV_MASS   = 3'd0;
    localparam logic [2:0] KIND_COULOMB    = 3'd1;
    localparam logic [2:0] KIND_VISCOUS    = 3'd2;
    localparam logic [2:0] KIND_PEAK_COUNT = 3'd3;
    localparam logic [2:0] KIND_HEIGHT     = 3'd4;
    localparam logic [2:0] KIND_CENTER     = 3'd5;
    localparam logic [2:0] KIND_INV_WIDTH  = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLING_TIME = 2'd0;
    localparam logic [1:0] CFG_NOISE_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_NOISE_SEED    = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         axis;
        logic signed [31:0] force_command;
        logic [2:0]         coef_kind;
        logic               coef_side;
        logic [2:0]         coef_peak;
        logic signed [31:0] coef_value;
    } fps_in_t;

    typedef struct packed {
        logic [2:0]         out_axis;
        logic signed [31:0] new_velocity;
        logic signed [47:0] new_position;
        logic signed [31:0] net_force;
        logic               saturated;
    } fps_out_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } motion_ctl_t;

    typedef struct packed {
        logic rd_en;
        logic wr_height;
        logic wr_center;
        logic wr_inv_width;
    } peak_ctl_t;

    // Entry i of exp(-i * 16 / depth) in Q2.30; ratio is the Q2.30 factor
    // from one entry to the next.
    function automatic logic [31:0] exp_rom_entry(int unsigned i, longint unsigned ratio);
        longint unsigned e;
        e = 64'd1 << 30;
        for (int unsigned n = 0; n < i; n++) begin
            e = (e * ratio + (64'd1 << 29)) >> 30;
        end
        return e[31:0];
    endfunction

endpackage

>>> rtl/fps_mul.sv
// Shared signed multiplier with a registered product.
// No package dependency; width set by the instantiating module.
module fps_mul #(
    parameter int W = 34
) (
    input  logic                  aclk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);
    always_ff @(posedge aclk) begin
        p <= a * b;
    end
endmodule

>>> rtl/fps_motion_store.sv
// Per-axis velocity and position memory with valid bits for reset and clear.
// Depends on fps_pkg.
module fps_motion_store #(
    parameter int AXES = 7,
    parameter int AW   = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fps_pkg::motion_ctl_t  ctl,
    input  logic [AW-1:0]         addr,
    input  logic signed [31:0]    wr_vel,
    input  logic signed [47:0]    wr_pos,
    output logic signed [31:0]    rd_vel,
    output logic signed [47:0]    rd_pos
);
    import fps_pkg::*;

    logic [79:0]      mem [AXES];
    logic [AXES-1:0]  valid_reg;
    logic [79:0]      rd_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= {wr_pos, wr_vel};
        end
        if (ctl.rd_en) begin
            rd_reg <= valid_reg[addr] ? mem[addr] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    assign rd_vel = $signed(rd_reg[31:0]);
    assign rd_pos = $signed(rd_reg[79:32]);
endmodule

>>> rtl/fps_peak_store.sv
// Peak height, center and reciprocal width memory, field write enables.
// Depends on fps_pkg; one valid bit per slot, unwritten fields read as zero.
module fps_peak_store #(
    parameter int SLOTS = 112,
    parameter int SW    = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fps_pkg::peak_ctl_t  ctl,
    input  logic [SW-1:0]       addr,
    input  logic signed [31:0]  wr_data,
    output logic signed [31:0]  rd_height,
    output logic signed [31:0]  rd_center,
    output logic signed [31:0]  rd_inv_width
);
    import fps_pkg::*;

    logic [95:0]      mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [95:0]      rd_reg;
    logic             wr_any;
    logic [95:0]      wr_first;

    assign wr_any   = ctl.wr_height || ctl.wr_center || ctl.wr_inv_width;
    assign wr_first = {ctl.wr_inv_width ? wr_data : 32'sd0,
                       ctl.wr_center    ? wr_data : 32'sd0,
                       ctl.wr_height    ? wr_data : 32'sd0};

    always_ff @(posedge aclk) begin
        if (wr_any) begin
            if (!valid_reg[addr]) begin
                // first write of a slot: zero the other fields
                mem[addr] <= wr_first;
            end else begin
                if (ctl.wr_height) begin
                    mem[addr][31:0] <= wr_data;
                end
                if (ctl.wr_center) begin
                    mem[addr][63:32] <= wr_data;
                end
                if (ctl.wr_inv_width) begin
                    mem[addr][95:64] <= wr_data;
                end
            end
        end
        if (ctl.rd_en) begin
            rd_reg <= valid_reg[addr] ? mem[addr] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_any) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    assign rd_height    = $signed(rd_reg[31:0]);
    assign rd_center    = $signed(rd_reg[63:32]);
    assign rd_inv_width = $signed(rd_reg[95:64]);
endmodule

>>> rtl/axis_friction_plant_step_top.sv
// Axis friction plant step: top level with sequencer, datapath and exp table.
// Depends on fps_pkg, fps_mul, fps_motion_store and fps_peak_store.
//
// One item is worked at a time. A step item runs the load and viscous states,
// the peak states once per active peak of the velocity side (up to PEAKS; a
// peak skips the exp table when out of range at either check), then the net
// force and Euler states. Its result is loaded once the output register is
// free, and the next item is accepted in the cycle after. Every friction,
// Gaussian and Euler product uses the single shared 34x34 multiplier.
// Coefficient writes, clears and ignored items leave the block idle. Motion
// state lives in a small memory read when a step item is accepted and written
// back when the result is loaded into the output register; the result waits
// there while the next item is accepted. Configuration writes are taken at any
// time the block is idle; a seed write reloads the noise LFSR at once.
module axis_friction_plant_step_top #(
    parameter int AXES            = fps_pkg::AXES_DEF,
    parameter int PEAKS           = fps_pkg::PEAKS_DEF,
    parameter int FRAC_BITS       = fps_pkg::FRAC_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = fps_pkg::EXP_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fps_pkg::fps_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fps_pkg::fps_out_t m_data,
    input  logic             cfg_wen,
    input  logic [1:0]       cfg_addr,
    input  logic [31:0]      cfg_wdata
);
    import fps_pkg::*;

    localparam int AW    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int ROWS  = AXES * 2;
    localparam int RW    = $clog2(ROWS);
    localparam int SLOTS = ROWS * PEAKS;
    localparam int SW    = $clog2(SLOTS);
    localparam int PW    = $clog2(PEAKS + 1);
    localparam int JW    = (PEAKS > 1) ? $clog2(PEAKS) : 1;
    localparam int EW    = $clog2(EXP_TABLE_DEPTH);
    localparam int ZSH   = FRAC_BITS + EXP_RANGE_LOG2 - EW;
    localparam longint unsigned KQ =
        (RECIP_SPREAD_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam longint unsigned EXP_STEP =
        (64'd1 << (30 + EXP_RANGE_LOG2)) / EXP_TABLE_DEPTH;
    // series terms of exp(-step) in Q2.30
    localparam longint unsigned EXP_ONE = 64'd1 << 30;
    localparam longint unsigned EXP_T1  = ((EXP_ONE * EXP_STEP) >> 30) / 1;
    localparam longint unsigned EXP_T2  = ((EXP_T1 * EXP_STEP) >> 30) / 2;
    localparam longint unsigned EXP_T3  = ((EXP_T2 * EXP_STEP) >> 30) / 3;
    localparam longint unsigned EXP_T4  = ((EXP_T3 * EXP_STEP) >> 30) / 4;
    localparam longint unsigned EXP_T5  = ((EXP_T4 * EXP_STEP) >> 30) / 5;
    localparam longint unsigned EXP_T6  = ((EXP_T5 * EXP_STEP) >> 30) / 6;
    localparam longint unsigned EXP_T7  = ((EXP_T6 * EXP_STEP) >> 30) / 7;
    localparam longint unsigned EXP_T8  = ((EXP_T7 * EXP_STEP) >> 30) / 8;
    localparam longint unsigned EXP_T9  = ((EXP_T8 * EXP_STEP) >> 30) / 9;
    localparam longint unsigned EXP_T10 = ((EXP_T9 * EXP_STEP) >> 30) / 10;
    localparam longint unsigned EXP_T11 = ((EXP_T10 * EXP_STEP) >> 30) / 11;
    localparam longint unsigned EXP_T12 = ((EXP_T11 * EXP_STEP) >> 30) / 12;
    localparam longint unsigned EXP_RATIO = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3
        + EXP_T4 - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9 + EXP_T10
        - EXP_T11 + EXP_T12;
    localparam logic [32:0] ROM_RND = 33'd1 << (29 - FRAC_BITS);
    localparam logic signed [PROD_W-1:0] S32_HI = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] S32_LO = PROD_W'(-64'sd2147483648);
    localparam logic signed [PROD_W-1:0] S48_HI = PROD_W'(64'sd140737488355327);
    localparam logic signed [PROD_W-1:0] S48_LO = PROD_W'(-64'sd140737488355328);
    localparam logic signed [PROD_W-1:0] NOISE_OFS = PROD_W'(64'sd1 << FRAC_BITS);

    typedef enum logic [17:0] {
        ST_IDLE   = 18'b000000000000000001,
        ST_LOAD   = 18'b000000000000000010,
        ST_VISC   = 18'b000000000000000100,
        ST_PK_D   = 18'b000000000000001000,
        ST_PK_U1  = 18'b000000000000010000,
        ST_PK_U2  = 18'b000000000000100000,
        ST_PK_Z   = 18'b000000000001000000,
        ST_PK_ROM = 18'b000000000010000000,
        ST_PK_H   = 18'b000000000100000000,
        ST_PK_ACC = 18'b000000001000000000,
        ST_NET    = 18'b000000010000000000,
        ST_MA     = 18'b000000100000000000,
        ST_ACC    = 18'b000001000000000000,
        ST_DV     = 18'b000010000000000000,
        ST_VEL    = 18'b000100000000000000,
        ST_DP     = 18'b001000000000000000,
        ST_POS    = 18'b010000000000000000,
        ST_OUT    = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [23:0] sampling_time_reg;
    logic        noise_enable_reg;
    logic [31:0] lfsr_reg;

    // coefficients held in flops, one entry per axis or row
    logic signed [31:0] imass_reg [AXES];
    logic signed [31:0] coul_reg  [AXES];
    logic signed [31:0] visc_reg  [AXES];
    logic [PW-1:0]      pcnt_reg  [ROWS];

    // step working registers
    logic [AW-1:0]      ax_reg;
    logic [2:0]         ax_out_reg;
    logic signed [31:0] force_reg;
    logic signed [31:0] v_reg;
    logic signed [47:0] pos_reg;
    logic [RW-1:0]      row_reg;
    logic [PW-1:0]      cnt_reg;
    logic [JW-1:0]      j_reg;
    logic signed [63:0] fr_reg;
    logic [FRAC_BITS:0] bump_reg;
    logic signed [31:0] net_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] vnew_reg;
    logic signed [47:0] pnew_reg;
    logic               sat_reg;

    logic               m_valid_reg;
    fps_out_t           out_reg;

    // exp table
    logic [31:0]        exp_rom [EXP_TABLE_DEPTH];
    logic [31:0]        rom_q_reg;
    logic [EW-1:0]      rom_addr;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    // stores
    motion_ctl_t        mctl;
    logic [AW-1:0]      maddr;
    logic signed [31:0] m_rd_vel;
    logic signed [47:0] m_rd_pos;
    peak_ctl_t          pctl;
    logic [SW-1:0]      paddr;
    logic signed [31:0] pk_height, pk_center, pk_inv_width;

    // combinational helpers
    logic                     accept;
    logic                     in_axis_ok;
    logic [AW-1:0]            in_ax;
    logic [RW-1:0]            in_row;
    logic [RW-1:0]            load_row;
    logic signed [32:0]       pk_diff;
    logic [32:0]              pk_ad;
    logic [31:0]              pk_aw;
    logic signed [PROD_W-1:0] shf;
    logic signed [PROD_W-1:0] dt_shf;
    logic signed [PROD_W-1:0] sum_x;
    logic signed [PROD_W-1:0] net_x;
    logic signed [PROD_W-1:0] noise_x;
    logic signed [63:0]       coul_term;
    logic [31:0]              lfsr_adv;
    logic [32:0]              rom_sum;
    logic                     out_free;

    genvar g;
    generate
        for (g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
            assign exp_rom[g] = exp_rom_entry(g, EXP_RATIO);
        end
    endgenerate

    fps_mul #(.W(MUL_W)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    fps_motion_store #(.AXES(AXES), .AW(AW)) u_motion (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mctl),
        .addr    (maddr),
        .wr_vel  (vnew_reg),
        .wr_pos  (pnew_reg),
        .rd_vel  (m_rd_vel),
        .rd_pos  (m_rd_pos)
    );

    fps_peak_store #(.SLOTS(SLOTS), .SW(SW)) u_peaks (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (pctl),
        .addr         (paddr),
        .wr_data      (s_data.coef_value),
        .rd_height    (pk_height),
        .rd_center    (pk_center),
        .rd_inv_width (pk_inv_width)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign in_axis_ok = (32'(s_data.axis) < AXES);
    assign in_ax      = AW'(s_data.axis);
    assign in_row     = RW'(32'(s_data.axis) * 2 + 32'(s_data.coef_side));
    assign load_row   = RW'(32'(ax_reg) * 2 + 32'(m_rd_vel[31]));
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = out_reg;

    // Gaussian distance terms
    assign pk_diff = 33'(v_reg) - 33'(pk_center);
    assign pk_ad   = pk_diff[32] ? 33'(-pk_diff) : 33'(pk_diff);
    assign pk_aw   = pk_inv_width[31] ? 32'(-pk_inv_width) : 32'(pk_inv_width);

    assign shf     = prod >>> FRAC_BITS;
    assign dt_shf  = prod >>> DT_SHIFT;
    assign rom_sum = 33'(rom_q_reg) + ROM_RND;
    assign rom_addr = EW'(prod >> (FRAC_BITS + ZSH));

    assign lfsr_adv  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);
    assign noise_x   = $signed({{(PROD_W-32){1'b0}}, lfsr_adv >> (31 - FRAC_BITS)})
                       - NOISE_OFS;
    assign net_x     = PROD_W'(force_reg) - PROD_W'(fr_reg)
                       + (noise_enable_reg ? noise_x : '0);
    assign coul_term = v_reg[31] ? -64'(coul_reg[ax_reg]) : 64'(coul_reg[ax_reg]);

    always_comb begin
        sum_x = '0;
        if (state_reg == ST_VEL) begin
            sum_x = PROD_W'(v_reg) + dt_shf;
        end else if (state_reg == ST_POS) begin
            sum_x = PROD_W'(pos_reg) + dt_shf;
        end
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOAD: begin
                mul_a = MUL_W'(visc_reg[ax_reg]);
                mul_b = MUL_W'(m_rd_vel);
            end
            ST_PK_D: begin
                mul_a = $signed({1'b0, pk_ad});
                mul_b = $signed({2'b0, pk_aw});
            end
            ST_PK_U1: begin
                mul_a = MUL_W'(shf);
                mul_b = MUL_W'(KQ);
            end
            ST_PK_U2: begin
                mul_a = MUL_W'(shf);
                mul_b = MUL_W'(shf);
            end
            ST_PK_H: begin
                mul_a = MUL_W'(pk_height);
                mul_b = $signed({{(MUL_W-FRAC_BITS-1){1'b0}}, bump_reg});
            end
            ST_MA: begin
                mul_a = MUL_W'(imass_reg[ax_reg]);
                mul_b = MUL_W'(net_reg);
            end
            ST_DV: begin
                mul_a = $signed({{(MUL_W-24){1'b0}}, sampling_time_reg});
                mul_b = MUL_W'(acc_reg);
            end
            ST_DP: begin
                mul_a = $signed({{(MUL_W-24){1'b0}}, sampling_time_reg});
                mul_b = MUL_W'(vnew_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // store control
    always_comb begin
        mctl  = '0;
        maddr = ax_reg;
        pctl  = '0;
        paddr = SW'(32'(row_reg) * PEAKS + 32'(j_reg) + 1);
        if (state_reg == ST_IDLE) begin
            maddr = in_ax;
            paddr = SW'(32'(in_row) * PEAKS + 32'(s_data.coef_peak));
            if (accept) begin
                mctl.clear   = (s_data.func == FUNC_CLEAR);
                mctl.rd_en   = (s_data.func == FUNC_STEP) && in_axis_ok;
                if ((s_data.func == FUNC_COEF) && in_axis_ok
                        && (32'(s_data.coef_peak) < PEAKS)) begin
                    pctl.wr_height    = (s_data.coef_kind == KIND_HEIGHT);
                    pctl.wr_center    = (s_data.coef_kind == KIND_CENTER);
                    pctl.wr_inv_width = (s_data.coef_kind == KIND_INV_WIDTH);
                end
            end
        end else if (state_reg == ST_LOAD) begin
            paddr      = SW'(32'(load_row) * PEAKS);
            pctl.rd_en = 1'b1;
        end else if (state_reg == ST_PK_ACC) begin
            pctl.rd_en = (32'(j_reg) + 1 < 32'(cnt_reg));
        end else if (state_reg == ST_OUT) begin
            mctl.wr_en = out_free;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.func == FUNC_STEP) && in_axis_ok) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:  state_next = ST_VISC;
            ST_VISC:  state_next = (cnt_reg == '0) ? ST_NET : ST_PK_D;
            ST_PK_D:  state_next = ST_PK_U1;
            ST_PK_U1: state_next = ((prod >> (2 * FRAC_BITS + EXP_RANGE_LOG2)) != '0)
                                   ? ST_PK_H : ST_PK_U2;
            ST_PK_U2: state_next = ST_PK_Z;
            ST_PK_Z:  state_next = ((prod >> (2 * FRAC_BITS + EXP_RANGE_LOG2)) != '0)
                                   ? ST_PK_H : ST_PK_ROM;
            ST_PK_ROM: state_next = ST_PK_H;
            ST_PK_H:   state_next = ST_PK_ACC;
            ST_PK_ACC: state_next = (32'(j_reg) + 1 < 32'(cnt_reg)) ? ST_PK_D : ST_NET;
            ST_NET:   state_next = ST_MA;
            ST_MA:    state_next = ST_ACC;
            ST_ACC:   state_next = ST_DV;
            ST_DV:    state_next = ST_VEL;
            ST_VEL:   state_next = ST_DP;
            ST_DP:    state_next = ST_POS;
            ST_POS:   state_next = ST_OUT;
            ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration and noise generator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sampling_time_reg <= 24'd16777;
            noise_enable_reg  <= 1'b1;
            lfsr_reg          <= 32'd1;
        end else begin
            if (cfg_wen) begin
                case (cfg_addr)
                    CFG_SAMPLING_TIME: sampling_time_reg <= cfg_wdata[23:0];
                    CFG_NOISE_ENABLE:  noise_enable_reg  <= cfg_wdata[0];
                    CFG_NOISE_SEED:    lfsr_reg <= (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
                    default: ;
                endcase
            end
            // advance once per step, noise on or off
            if (state_reg == ST_NET) begin
                lfsr_reg <= lfsr_adv;
            end
        end
    end

    // coefficient writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                imass_reg[i] <= '0;
                coul_reg[i]  <= '0;
                visc_reg[i]  <= '0;
            end
            for (int i = 0; i < ROWS; i++) begin
                pcnt_reg[i] <= '0;
            end
        end else if (accept && (s_data.func == FUNC_COEF) && in_axis_ok) begin
            case (s_data.coef_kind)
                KIND_INV_MASS: imass_reg[in_ax] <= s_data.coef_value;
                KIND_COULOMB:  coul_reg[in_ax]  <= s_data.coef_value;
                KIND_VISCOUS:  visc_reg[in_ax]  <= s_data.coef_value;
                KIND_PEAK_COUNT: begin
                    // clamp to 0..PEAKS
                    if (s_data.coef_value < 0) begin
                        pcnt_reg[in_row] <= '0;
                    end else if (s_data.coef_value > PEAKS) begin
                        pcnt_reg[in_row] <= PW'(PEAKS);
                    end else begin
                        pcnt_reg[in_row] <= s_data.coef_value[PW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // step datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ax_reg     <= in_ax;
                ax_out_reg <= s_data.axis;
                force_reg  <= s_data.force_command;
            end
            ST_LOAD: begin
                v_reg   <= m_rd_vel;
                pos_reg <= m_rd_pos;
                row_reg <= load_row;
                cnt_reg <= pcnt_reg[load_row];
                j_reg   <= '0;
                sat_reg <= 1'b0;
            end
            ST_VISC: begin
                fr_reg <= coul_term + 64'(shf);
            end
            ST_PK_U1: begin
                bump_reg <= '0;
            end
            ST_PK_Z: begin
                bump_reg  <= '0;
                rom_q_reg <= exp_rom[rom_addr];
            end
            ST_PK_ROM: begin
                bump_reg <= (FRAC_BITS + 1)'(rom_sum >> (30 - FRAC_BITS));
            end
            ST_PK_ACC: begin
                fr_reg <= fr_reg + 64'(shf);
                j_reg  <= JW'(32'(j_reg) + 1);
            end
            ST_NET: begin
                if (net_x > S32_HI) begin
                    net_reg <= 32'(S32_HI);
                    sat_reg <= 1'b1;
                end else if (net_x < S32_LO) begin
                    net_reg <= 32'(S32_LO);
                    sat_reg <= 1'b1;
                end else begin
                    net_reg <= 32'(net_x);
                end
            end
            ST_ACC: begin
                if (shf > S32_HI) begin
                    acc_reg <= 32'(S32_HI);
                    sat_reg <= 1'b1;
                end else if (shf < S32_LO) begin
                    acc_reg <= 32'(S32_LO);
                    sat_reg <= 1'b1;
                end else begin
                    acc_reg <= 32'(shf);
                end
            end
            ST_VEL: begin
                if (sum_x > S32_HI) begin
                    vnew_reg <= 32'(S32_HI);
                    sat_reg  <= 1'b1;
                end else if (sum_x < S32_LO) begin
                    vnew_reg <= 32'(S32_LO);
                    sat_reg  <= 1'b1;
                end else begin
                    vnew_reg <= 32'(sum_x);
                end
            end
            ST_POS: begin
                if (sum_x > S48_HI) begin
                    pnew_reg <= 48'(S48_HI);
                    sat_reg  <= 1'b1;
                end else if (sum_x < S48_LO) begin
                    pnew_reg <= 48'(S48_LO);
                    sat_reg  <= 1'b1;
                end else begin
                    pnew_reg <= 48'(sum_x);
                end
            end
            default: ;
        endcase
    end

    // result register: hold until taken, load from the final step state
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            out_reg.out_axis     <= ax_out_reg;
            out_reg.new_velocity <= vnew_reg;
            out_reg.new_position <= pnew_reg;
            out_reg.net_force    <= net_reg;
            out_reg.saturated    <= sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // the noise LFSR must never lock up at zero
    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0) else $error("noise LFSR reached zero");

    // peak loop never runs past the row's peak count
    a_peak_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PK_D) |-> (32'(j_reg) < 32'(cnt_reg)))
        else $error("peak index beyond count");

    // a finished step shows its result and frees the block in the next cycle
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not loaded");

endmodule
